// ===== rtl/abr_pkg.sv =====
`default_nettype none
package abr_pkg;

  localparam int MEM_WORDS = 64;
  localparam int ADDR_W    = $clog2(MEM_WORDS);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [7:0] OP_READ       = 8'd1;
  localparam logic [7:0] OP_READ_WIDE  = 8'd2;
  localparam logic [7:0] OP_WRITE      = 8'd3;
  localparam logic [7:0] OP_WRITE_WIDE = 8'd4;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_E     = 8'h65;

  localparam logic [4:0] POS_MAX = 5'd31;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_FORMAT  = 3'd1,
    ERR_ADDRESS = 3'd2,
    ERR_OPCODE  = 3'd3,
    ERR_DENIED  = 3'd4
  } err_t;

  // one decoded command line, handed from the parser to the executor
  typedef struct packed {
    err_t              err;
    logic              wr;
    logic              wide;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       lo;
    logic [15:0]       hi;
  } cmd_t;

  // {ok, digit}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) r = 8'h30 + {4'd0, n};
    else r = 8'h57 + {4'd0, n};
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ascii_hex_register_access_bridge.sv =====
`default_nettype none
// channel   direction  handshake                 payload
// in        input      in_valid / in_stall       in_char[7:0]
// out       output     out_valid / out_stall     out_char[7:0], out_last
// cfg       input      psel/penable/pwrite/pready  paddr[3:0], pwdata[63:0], prdata[63:0]
//
// characters are taken one per cycle unless in_stall is high, which it is while the
// two-entry command queue is full; only a newline enters that queue.
// the executor goes straight to emitting for an error, writes the low (and if wide the
// high) word, or reads and captures them; text leaves at one character per cycle, unless
// stalled, through the output register; the word memory has one read and one write port.
// rst is synchronous and clears the parser, queue, word valid bits and mask at once.
// out_stall holds the output register; the parser keeps running until the queue fills.
module ascii_hex_register_access_bridge
  import abr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_char,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  logic [63:0] mask;
  logic        q_full;
  logic        q_push;
  cmd_t        q_cmd;
  logic        q_avail;
  logic        q_pop;
  cmd_t        q_head;

  assign pready = 1'b1;
  assign prdata = paddr[3] ? 64'd0 : mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= 64'd0;
    end else if (psel && penable && pwrite && pready && !paddr[3]) begin
      mask <= pwdata;
    end
  end

  abr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_char  (in_char),
    .mask     (mask),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  abr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .avail    (q_avail),
    .pop      (q_pop),
    .head     (q_head)
  );

  abr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_avail   (q_avail),
    .q_pop     (q_pop),
    .q_head    (q_head),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .out_last  (out_last)
  );

endmodule
`default_nettype wire

// ===== rtl/abr_ram.sv =====
`default_nettype none
module abr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/abr_front.sv =====
`default_nettype none
module abr_front
  import abr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char,
  input  wire logic [63:0] mask,
  input  wire logic        q_full,
  output logic             q_push,
  output cmd_t             q_cmd
);

  logic [4:0]  pos;
  logic [7:0]  op_acc;
  logic [15:0] addr_acc;
  logic [31:0] val_acc;
  logic        bad;
  logic        accept;
  logic        is_nl;
  logic [4:0]  dec;
  logic [4:0]  need;
  logic        known_op;
  logic        is_wide;
  logic        is_wr;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_nl    = (in_char == CH_NL);
  assign dec      = hex_decode(in_char);
  assign q_push   = accept && is_nl;

  always_comb begin
    is_wide  = (op_acc == OP_READ_WIDE) || (op_acc == OP_WRITE_WIDE);
    is_wr    = (op_acc == OP_WRITE) || (op_acc == OP_WRITE_WIDE);
    known_op = (op_acc == OP_READ) || (op_acc == OP_READ_WIDE) || is_wr;
    if (op_acc == OP_WRITE) need = 5'd11;
    else if (op_acc == OP_WRITE_WIDE) need = 5'd15;
    else need = 5'd7;

    q_cmd.wr   = is_wr;
    q_cmd.wide = is_wide;
    q_cmd.addr = addr_acc[ADDR_W-1:0];
    q_cmd.hi   = val_acc[31:16];
    // a narrow write keeps the first four value digits
    if (op_acc == OP_WRITE_WIDE || pos >= 5'd15) q_cmd.lo = is_wide ? val_acc[15:0]
                                                                    : val_acc[31:16];
    else if (pos == 5'd14) q_cmd.lo = val_acc[27:12];
    else if (pos == 5'd13) q_cmd.lo = val_acc[23:8];
    else if (pos == 5'd12) q_cmd.lo = val_acc[19:4];
    else q_cmd.lo = val_acc[15:0];

    if (bad || pos < need) q_cmd.err = ERR_FORMAT;
    else if (addr_acc >= 16'(MEM_WORDS)) q_cmd.err = ERR_ADDRESS;
    else if (!known_op) q_cmd.err = ERR_OPCODE;
    else if (is_wide && addr_acc == 16'(MEM_WORDS - 1)) q_cmd.err = ERR_ADDRESS;
    else if (is_wr && mask[addr_acc[5:0]]) q_cmd.err = ERR_DENIED;
    else q_cmd.err = ERR_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= 5'd0;
      op_acc   <= 8'd0;
      addr_acc <= 16'd0;
      val_acc  <= 32'd0;
      bad      <= 1'b0;
    end else if (accept) begin
      if (is_nl) begin
        pos      <= 5'd0;
        op_acc   <= 8'd0;
        addr_acc <= 16'd0;
        val_acc  <= 32'd0;
        bad      <= 1'b0;
      end else begin
        if (pos == 5'd0) begin
          if (in_char != CH_COLON) bad <= 1'b1;
        end else if (pos < POS_MAX) begin
          if (!dec[4]) bad <= 1'b1;
          else if (pos <= 5'd2) op_acc <= {op_acc[3:0], dec[3:0]};
          else if (pos <= 5'd6) addr_acc <= {addr_acc[11:0], dec[3:0]};
          else if (pos <= 5'd14) val_acc <= {val_acc[27:0], dec[3:0]};
        end
        if (pos < POS_MAX) pos <= pos + 5'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/abr_queue.sv =====
`default_nettype none
module abr_queue
  import abr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  output logic      avail,
  input  wire logic pop,
  output cmd_t      head
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign avail = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/abr_back.sv =====
`default_nettype none
module abr_back
  import abr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_avail,
  output logic            q_pop,
  input  cmd_t            q_head,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_char,
  output logic            out_last
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_WR_LO = 7'b0000010,
    S_WR_HI = 7'b0000100,
    S_RD_LO = 7'b0001000,
    S_RD_HI = 7'b0010000,
    S_CAP   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t            state, state_next;
  cmd_t              cmd, cmd_next;
  logic [47:0]       line, line_next;
  logic [3:0]        cnt, cnt_next;
  logic              lead_e, lead_e_next;
  logic [15:0]       lo_rd, lo_rd_next;
  logic [MEM_WORDS-1:0] vbits;
  logic              rvld;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [15:0]       wdata;
  logic [ADDR_W-1:0] raddr;
  logic [15:0]       rdata;
  logic [15:0]       rd_eff;
  logic [15:0]       addr16;
  logic              out_free;
  logic              emit;
  logic [7:0]        emit_char;
  logic              emit_last;

  abr_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // never-written words read as zero
  assign rd_eff   = rvld ? rdata : 16'd0;
  assign addr16   = 16'(cmd.addr);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next  = state;
    cmd_next    = cmd;
    line_next   = line;
    cnt_next    = cnt;
    lead_e_next = lead_e;
    lo_rd_next  = lo_rd;
    q_pop       = 1'b0;
    we          = 1'b0;
    waddr       = cmd.addr;
    wdata       = cmd.lo;
    raddr       = cmd.addr;
    emit        = 1'b0;
    emit_char   = CH_NL;
    emit_last   = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_avail) begin
          q_pop    = 1'b1;
          cmd_next = q_head;
          if (q_head.err != ERR_NONE) begin
            line_next   = {13'd0, q_head.err, 32'd0};
            cnt_next    = 4'd4;
            lead_e_next = 1'b1;
            state_next  = S_EMIT;
          end else if (q_head.wr) begin
            state_next = S_WR_LO;
          end else begin
            state_next = S_RD_LO;
          end
        end
      end
      S_WR_LO: begin
        we = 1'b1;
        if (cmd.wide) begin
          state_next = S_WR_HI;
        end else begin
          line_next  = {addr16, cmd.lo, 16'd0};
          cnt_next   = 4'd8;
          state_next = S_EMIT;
        end
      end
      S_WR_HI: begin
        we         = 1'b1;
        waddr      = cmd.addr + 1'b1;
        wdata      = cmd.hi;
        line_next  = {addr16, cmd.hi, cmd.lo};
        cnt_next   = 4'd12;
        state_next = S_EMIT;
      end
      S_RD_LO: begin
        state_next = cmd.wide ? S_RD_HI : S_CAP;
      end
      S_RD_HI: begin
        raddr      = cmd.addr + 1'b1;
        lo_rd_next = rd_eff;
        state_next = S_CAP;
      end
      S_CAP: begin
        if (cmd.wide) begin
          line_next = {addr16, rd_eff, lo_rd};
          cnt_next  = 4'd12;
        end else begin
          line_next = {addr16, rd_eff, 16'd0};
          cnt_next  = 4'd8;
        end
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (lead_e) begin
            emit_char   = CH_E;
            lead_e_next = 1'b0;
          end else if (cnt != 4'd0) begin
            emit_char = hex_char(line[47:44]);
            line_next = {line[43:0], 4'd0};
            cnt_next  = cnt - 4'd1;
          end else begin
            emit_last  = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vbits     <= '0;
      out_valid <= 1'b0;
      lead_e    <= 1'b0;
      cnt       <= 4'd0;
    end else begin
      state  <= state_next;
      lead_e <= lead_e_next;
      cnt    <= cnt_next;
      if (we) vbits[waddr] <= 1'b1;
      if (out_free) out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    cmd   <= cmd_next;
    line  <= line_next;
    lo_rd <= lo_rd_next;
    rvld  <= vbits[raddr];
    if (out_free && emit) begin
      out_char <= emit_char;
      out_last <= emit_last;
    end
  end

endmodule
`default_nettype wire
